[design/lrt_pkg.sv]
package lrt_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 2;
    localparam int COST_W   = 8;
    localparam int TTL_W    = 8;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FORWARD = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FORWARDED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOROUTE   = 3'd7;

    // One route as held in the table memory.
    typedef struct packed {
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
        logic [COST_W-1:0] cost;
        logic              direct;
    } entry_t;

    // Verdict of the compare unit on one table entry.
    typedef struct packed {
        logic             hit;
        logic [LEN_W-1:0] len;
    } match_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   hop;
        logic [PORT_W-1:0]   port;
        logic [TTL_W-1:0]    ttl;
        logic [COST_W-1:0]   cost;
        logic [LEN_W-1:0]    plen;
    } result_t;

endpackage

[design/lrt_entry_ram.sv]
module lrt_entry_ram #(
    parameter int DEPTH = lrt_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  lrt_pkg::entry_t      wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output lrt_pkg::entry_t      rdata
);

    lrt_pkg::entry_t mem [DEPTH];
    lrt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/lrt_match_unit.sv]
module lrt_match_unit (
    input  logic                       is_delete,
    input  lrt_pkg::entry_t            entry,
    input  logic [lrt_pkg::ADDR_W-1:0] key_addr,
    input  logic [lrt_pkg::ADDR_W-1:0] key_mask,
    input  logic [lrt_pkg::ADDR_W-1:0] dest,
    output lrt_pkg::match_t            result
);

    logic [lrt_pkg::LEN_W-1:0] ones;

    // Prefix length is the number of set bits in the entry mask.
    always_comb
    begin
        ones = '0;
        for (int b = 0; b < lrt_pkg::ADDR_W; b++)
        begin
            ones = ones + lrt_pkg::LEN_W'(entry.mask[b]);
        end
    end

    always_comb
    begin
        if (is_delete)
        begin
            result.hit = (entry.net == key_addr) && (entry.mask == key_mask);
        end
        else
        begin
            result.hit = ((dest & entry.mask) == entry.net);
        end
        result.len = ones;
    end

endmodule

[design/lpm_route_table.sv]
// Longest-prefix-match route table with one compare unit swept over a table memory.
// An expired forward finishes at once; an add writes or bounces in S_ADD; a forward or missed
// delete sweeps every stored entry; a delete hit sweeps to the hit, then shifts the rest down.
// One entry is read per cycle through the single read port; the next transaction is taken
// in the cycle after the result loads, and a result held by the sink stalls the sequencer.
// rst_n clears the sequencer, route count and output valid; table contents stay undefined.
module lpm_route_table #(
    parameter int TABLE_DEPTH = lrt_pkg::TABLE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // From bit 0: net_addr(32), net_mask(32), hop_addr(32), port_in(2), cost_in(8),
    // dest_addr(32), ttl_in(8), then six zero bits.
    input  logic [151:0] s_axis_tdata,
    // From bit 0: op(2), connected(1).
    input  logic [2:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // From bit 0: hop_out(32), port_out(2), ttl_out(8), cost_out(8), pfx_len(6).
    output logic [55:0]  m_axis_tdata,
    // From bit 0: status(3).
    output logic [2:0]   m_axis_tuser
);

    // Index width for the memory, and a count width that can hold the depth itself.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;

    // Scan pipeline: rd_idx is the next entry to read, chk_idx the entry whose data
    // is on the memory output this cycle.
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          chk_valid_reg, chk_valid_next;

    // Captured transaction fields.
    logic [lrt_pkg::OP_W-1:0]   op_reg, op_next;
    logic [lrt_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [lrt_pkg::ADDR_W-1:0] mask_reg, mask_next;
    logic [lrt_pkg::ADDR_W-1:0] hop_reg, hop_next;
    logic [lrt_pkg::PORT_W-1:0] port_reg, port_next;
    logic [lrt_pkg::COST_W-1:0] cost_reg, cost_next;
    logic                       conn_reg, conn_next;
    logic [lrt_pkg::ADDR_W-1:0] dest_reg, dest_next;
    logic [lrt_pkg::TTL_W-1:0]  ttl_reg, ttl_next;

    // Best route seen so far during a forward scan.
    logic                       found_reg, found_next;
    lrt_pkg::entry_t            best_reg, best_next;
    logic [lrt_pkg::LEN_W-1:0]  best_len_reg, best_len_next;

    lrt_pkg::result_t pend_reg, pend_next;
    lrt_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    lrt_pkg::entry_t  ram_wdata;
    logic             ram_re;
    lrt_pkg::entry_t  ram_rdata;
    lrt_pkg::entry_t  add_entry;
    lrt_pkg::match_t  match;
    logic             accept;
    logic             issue;

    lrt_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    lrt_match_unit u_match (
        .is_delete (op_reg == lrt_pkg::OP_DELETE),
        .entry     (ram_rdata),
        .key_addr  (addr_reg),
        .key_mask  (mask_reg),
        .dest      (dest_reg),
        .result    (match)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign issue         = (rd_idx_reg < count_reg);

    // A connected route keeps only the masked network and has no next hop.
    always_comb
    begin
        add_entry.net    = conn_reg ? (addr_reg & mask_reg) : addr_reg;
        add_entry.mask   = mask_reg;
        add_entry.hop    = conn_reg ? '0 : hop_reg;
        add_entry.port   = port_reg;
        add_entry.cost   = cost_reg;
        add_entry.direct = conn_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = 1'b0;
        op_next        = op_reg;
        addr_next      = addr_reg;
        mask_next      = mask_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        cost_next      = cost_reg;
        conn_next      = conn_reg;
        dest_next      = dest_reg;
        ttl_next       = ttl_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_len_next  = best_len_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = add_entry;
        ram_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = s_axis_tuser[1:0];
                    conn_next   = s_axis_tuser[2];
                    addr_next   = s_axis_tdata[31:0];
                    mask_next   = s_axis_tdata[63:32];
                    hop_next    = s_axis_tdata[95:64];
                    port_next   = s_axis_tdata[97:96];
                    cost_next   = s_axis_tdata[105:98];
                    dest_next   = s_axis_tdata[137:106];
                    ttl_next    = s_axis_tdata[145:138];
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    pend_next   = '0;
                    case (s_axis_tuser[1:0])
                        lrt_pkg::OP_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        lrt_pkg::OP_DELETE:
                        begin
                            state_next = S_SCAN;
                        end
                        lrt_pkg::OP_FORWARD:
                        begin
                            if (s_axis_tdata[145:138] == '0)
                            begin
                                pend_next.status = lrt_pkg::ST_EXPIRED;
                                state_next       = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // The unused code is dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                if (count_reg == CW'(TABLE_DEPTH))
                begin
                    pend_next.status = lrt_pkg::ST_FULL;
                end
                else
                begin
                    ram_we           = 1'b1;
                    count_next       = count_reg + CW'(1);
                    pend_next.status = lrt_pkg::ST_ADDED;
                end
                state_next = S_FINISH;
            end

            S_SCAN:
            begin
                ram_re         = issue;
                chk_valid_next = issue;
                chk_idx_next   = rd_idx_reg[AW-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (chk_valid_reg)
                begin
                    if (op_reg == lrt_pkg::OP_DELETE)
                    begin
                        if (match.hit)
                        begin
                            // Later entries move down one place, starting after the hit.
                            rd_idx_next    = CW'(chk_idx_reg) + CW'(1);
                            chk_valid_next = 1'b0;
                            state_next     = S_SHIFT;
                        end
                    end
                    else if (match.hit && (!found_reg || (match.len > best_len_reg)))
                    begin
                        found_next    = 1'b1;
                        best_next     = ram_rdata;
                        best_len_next = match.len;
                    end
                end
                else if (!issue)
                begin
                    state_next = S_FINISH;
                    if (op_reg == lrt_pkg::OP_DELETE)
                    begin
                        pend_next.status = lrt_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        pend_next.ttl = ttl_reg - lrt_pkg::TTL_W'(1);
                        if (!found_reg)
                        begin
                            pend_next.status = lrt_pkg::ST_NOROUTE;
                        end
                        else
                        begin
                            pend_next.port = best_reg.port;
                            pend_next.cost = best_reg.cost;
                            pend_next.plen = best_len_reg;
                            if (best_reg.direct)
                            begin
                                pend_next.status = lrt_pkg::ST_DELIVERED;
                            end
                            else
                            begin
                                pend_next.status = lrt_pkg::ST_FORWARDED;
                                pend_next.hop    = best_reg.hop;
                            end
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                ram_re         = issue;
                chk_valid_next = issue;
                chk_idx_next   = rd_idx_reg[AW-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (chk_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = chk_idx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                else if (!issue)
                begin
                    count_next       = count_reg - CW'(1);
                    pend_next.status = lrt_pkg::ST_DELETED;
                    state_next       = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        mask_reg     <= mask_next;
        hop_reg      <= hop_next;
        port_reg     <= port_next;
        cost_reg     <= cost_next;
        conn_reg     <= conn_next;
        dest_reg     <= dest_next;
        ttl_reg      <= ttl_next;
        best_reg     <= best_next;
        best_len_reg <= best_len_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.plen, out_reg.cost, out_reg.ttl, out_reg.port, out_reg.hop};
    assign m_axis_tuser  = out_reg.status;

`ifndef SYNTHESIS
    // The route count never runs past the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("route count exceeds table depth");

    // The route count only moves by one per operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + CW'(1)) || (count_reg == $past(count_reg) - CW'(1))))
        else $error("route count jumped");

    // Direct delivery never reports a next hop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == lrt_pkg::ST_DELIVERED)) |-> (m_axis_tdata[31:0] == '0))
        else $error("delivered result carries a next hop");

    // A table rewrite only happens while a delete shifts entries down or an add appends.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_SHIFT) || (state_reg == S_ADD)))
        else $error("table written outside add or delete");
`endif

endmodule

[tb/lpm_route_table_tb.sv]
module lpm_route_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = lrt_pkg::TABLE_DEPTH_DEF;

    // The op field has one code that the block ignores; it must produce no result.
    localparam logic [lrt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Generous ceiling on the whole run. The slowest legal transaction is a forward or
    // a delete on a full table, which costs about one table sweep.
    localparam int CYCLE_LIMIT = 3_000_000;

    // Quiet period after the last result, long enough for one more full sweep.
    localparam int TAIL_CYCLES = 2 * TBL_DEPTH + 16;

    // One request as the sender sees it, before packing onto the bus.
    typedef struct packed {
        logic [lrt_pkg::OP_W-1:0]   op;
        logic                       connected;
        logic [lrt_pkg::ADDR_W-1:0] net_addr;
        logic [lrt_pkg::ADDR_W-1:0] net_mask;
        logic [lrt_pkg::ADDR_W-1:0] hop_addr;
        logic [lrt_pkg::PORT_W-1:0] port_in;
        logic [lrt_pkg::COST_W-1:0] cost_in;
        logic [lrt_pkg::ADDR_W-1:0] dest_addr;
        logic [lrt_pkg::TTL_W-1:0]  ttl_in;
    } route_req_t;

    // A row of the directed table. When has_literal is set the answer written in the
    // row is the expectation; otherwise the route predictor supplies it.
    typedef struct {
        route_req_t       req;
        bit               has_literal;
        lrt_pkg::result_t literal;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;

    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // From bit 0: net_addr(32), net_mask(32), hop_addr(32), port_in(2), cost_in(8),
    // dest_addr(32), ttl_in(8), then six zero bits.
    logic [151:0] s_axis_tdata = '0;
    // From bit 0: op(2), connected(1).
    logic [2:0]   s_axis_tuser = '0;

    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // From bit 0: hop_out(32), port_out(2), ttl_out(8), cost_out(8), pfx_len(6).
    logic [55:0]  m_axis_tdata;
    // From bit 0: status(3).
    logic [2:0]   m_axis_tuser;

    // Shadow copy of the route table, kept in the same order as the block keeps it.
    lrt_pkg::entry_t  routes [TBL_DEPTH];
    int               shadow_count = 0;

    // Results still owed by the block, oldest first.
    lrt_pkg::result_t expected_results [$];
    stim_row_t        stim_table [$];

    int           err_count = 0;
    int           cycle_count = 0;

    // While set, neither side of the bus inserts idle cycles.
    bit           steady = 1'b0;

    lpm_route_table #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Route predictor. It applies one request to the shadow table and returns 1 when
    // the request produces a result, which is then written to res.
    function automatic bit predict_route(input route_req_t rq, output lrt_pkg::result_t res);
        int hit_idx;
        int best_len;
        int len;
        res = '0;
        case (rq.op)
            lrt_pkg::OP_ADD:
            begin
                if (shadow_count >= TBL_DEPTH)
                begin
                    res.status = lrt_pkg::ST_FULL;
                end
                else
                begin
                    // A connected route keeps only the network part and has no gateway.
                    routes[shadow_count].net    = rq.connected ? (rq.net_addr & rq.net_mask)
                                                               : rq.net_addr;
                    routes[shadow_count].mask   = rq.net_mask;
                    routes[shadow_count].hop    = rq.connected ? '0 : rq.hop_addr;
                    routes[shadow_count].port   = rq.port_in;
                    routes[shadow_count].cost   = rq.cost_in;
                    routes[shadow_count].direct = rq.connected;
                    shadow_count++;
                    res.status = lrt_pkg::ST_ADDED;
                end
            end
            lrt_pkg::OP_DELETE:
            begin
                res.status = lrt_pkg::ST_NOTFOUND;
                hit_idx = -1;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (hit_idx < 0 && routes[i].net == rq.net_addr
                        && routes[i].mask == rq.net_mask)
                        hit_idx = i;
                end
                if (hit_idx >= 0)
                begin
                    // Later routes close the gap so that their order is preserved.
                    for (int j = hit_idx; j < shadow_count - 1; j++)
                        routes[j] = routes[j + 1];
                    shadow_count--;
                    res.status = lrt_pkg::ST_DELETED;
                end
            end
            lrt_pkg::OP_FORWARD:
            begin
                if (rq.ttl_in == 0)
                begin
                    res.status = lrt_pkg::ST_EXPIRED;
                end
                else
                begin
                    res.ttl = rq.ttl_in - 1'b1;
                    hit_idx = -1;
                    best_len = -1;
                    // Strictly longer prefixes win, so the earliest of equal ones stays.
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        if ((rq.dest_addr & routes[i].mask) == routes[i].net)
                        begin
                            len = $countones(routes[i].mask);
                            if (len > best_len)
                            begin
                                best_len = len;
                                hit_idx = i;
                            end
                        end
                    end
                    if (hit_idx < 0)
                    begin
                        res.status = lrt_pkg::ST_NOROUTE;
                    end
                    else
                    begin
                        res.port = routes[hit_idx].port;
                        res.cost = routes[hit_idx].cost;
                        res.plen = best_len[lrt_pkg::LEN_W-1:0];
                        if (routes[hit_idx].direct)
                        begin
                            res.status = lrt_pkg::ST_DELIVERED;
                        end
                        else
                        begin
                            res.status = lrt_pkg::ST_FORWARDED;
                            res.hop = routes[hit_idx].hop;
                        end
                    end
                end
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic route_req_t make_req(
        input logic [lrt_pkg::OP_W-1:0]   op,
        input logic                       connected,
        input logic [lrt_pkg::ADDR_W-1:0] net_addr,
        input logic [lrt_pkg::ADDR_W-1:0] net_mask,
        input logic [lrt_pkg::ADDR_W-1:0] hop_addr,
        input logic [lrt_pkg::PORT_W-1:0] port_in,
        input logic [lrt_pkg::COST_W-1:0] cost_in,
        input logic [lrt_pkg::ADDR_W-1:0] dest_addr,
        input logic [lrt_pkg::TTL_W-1:0]  ttl_in
    );
        route_req_t rq;
        rq.op        = op;
        rq.connected = connected;
        rq.net_addr  = net_addr;
        rq.net_mask  = net_mask;
        rq.hop_addr  = hop_addr;
        rq.port_in   = port_in;
        rq.cost_in   = cost_in;
        rq.dest_addr = dest_addr;
        rq.ttl_in    = ttl_in;
        return rq;
    endfunction

    task automatic add_row(input route_req_t rq, input bit has_literal,
                           input lrt_pkg::result_t lit);
        stim_row_t r;
        r.req = rq;
        r.has_literal = has_literal;
        r.literal = lit;
        stim_table.push_back(r);
    endtask

    // Builds one random request. The add and delete shares are given in percent; a few
    // percent are the ignored op code and the rest are packet forwards. Adds mostly use
    // contiguous prefix masks over a handful of top bytes so that routes overlap, and
    // deletes and forwards mostly aim at routes that are in the table.
    function automatic route_req_t rand_route_op(input int add_pct, input int del_pct);
        route_req_t  rq;
        int          roll;
        int          pick;
        int          plen;
        logic [7:0]  top_bytes [4];
        top_bytes = '{8'h0A, 8'hAC, 8'hC0, 8'hFF};
        rq.op        = lrt_pkg::OP_FORWARD;
        rq.connected = 1'($urandom_range(1));
        rq.net_addr  = $urandom;
        rq.net_mask  = $urandom;
        rq.hop_addr  = $urandom;
        rq.port_in   = lrt_pkg::PORT_W'($urandom_range(3));
        rq.cost_in   = lrt_pkg::COST_W'($urandom_range(255));
        rq.dest_addr = $urandom;
        rq.ttl_in    = lrt_pkg::TTL_W'($urandom_range(255));
        plen = $urandom_range(32);
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            rq.op = OP_UNUSED;
        end
        else if (roll < 3 + add_pct)
        begin
            rq.op = lrt_pkg::OP_ADD;
            // Now and then keep a scattered mask, which is legal but unusual.
            if ($urandom_range(19) != 0)
                rq.net_mask = 32'hFFFF_FFFF << (32 - plen);
            rq.net_addr[31:24] = top_bytes[$urandom_range(3)];
            // Most static routes are clean; the rest carry host bits and never match.
            if (!rq.connected && $urandom_range(9) < 7)
                rq.net_addr &= rq.net_mask;
        end
        else if (roll < 3 + add_pct + del_pct)
        begin
            rq.op = lrt_pkg::OP_DELETE;
            if (shadow_count > 0 && $urandom_range(3) != 0)
            begin
                pick = $urandom_range(shadow_count - 1);
                rq.net_addr = routes[pick].net;
                rq.net_mask = routes[pick].mask;
            end
            else
            begin
                rq.net_mask = 32'hFFFF_FFFF << (32 - plen);
            end
        end
        else
        begin
            if (shadow_count > 0 && $urandom_range(4) != 0)
            begin
                pick = $urandom_range(shadow_count - 1);
                rq.dest_addr = (routes[pick].net & routes[pick].mask)
                             | (rq.dest_addr & ~routes[pick].mask);
            end
            case ($urandom_range(9))
                0:       rq.ttl_in = '0;
                1:       rq.ttl_in = 8'd1;
                default: ;
            endcase
        end
        return rq;
    endfunction

    // Drives one request transaction and, once it is accepted, records the result the
    // block owes for it. Called right after a rising edge, so every assignment here
    // lands in a step of its own.
    task automatic send_route_op(input route_req_t rq, input bit has_literal,
                                 input lrt_pkg::result_t lit);
        lrt_pkg::result_t predicted;
        bit               has_res;
        if (!steady && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, rq.ttl_in, rq.dest_addr, rq.cost_in, rq.port_in,
                          rq.hop_addr, rq.net_mask, rq.net_addr};
        s_axis_tuser  <= {rq.connected, rq.op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        // The predictor always runs so that the shadow table follows every transaction.
        has_res = predict_route(rq, predicted);
        if (has_res)
            expected_results.push_back(has_literal ? lit : predicted);
    endtask

    // Random traffic that steers the table size toward a target.
    task automatic run_mix(input int n_items, input int target);
        repeat (n_items)
            send_route_op(rand_route_op(shadow_count < target ? 45 : 15,
                                        shadow_count > target ? 35 : 20), 1'b0, '0);
    endtask

    // Holds the sender off until the block has delivered everything it owes.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random back-pressure, and a check of every accepted transaction
    // against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        lrt_pkg::result_t got;
        lrt_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tuser;
            got.hop    = m_axis_tdata[31:0];
            got.port   = m_axis_tdata[33:32];
            got.ttl    = m_axis_tdata[41:34];
            got.cost   = m_axis_tdata[49:42];
            got.plen   = m_axis_tdata[55:50];
            if (expected_results.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: status %0d hop %h port %0d ttl %0d cost %0d len %0d",
                             got.status, got.hop, got.port, got.ttl, got.cost, got.plen);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.hop !== want.hop
                    || got.port !== want.port || got.ttl !== want.ttl
                    || got.cost !== want.cost || got.plen !== want.plen)
                begin
                    err_count++;
                    if (err_count <= 10)
                    begin
                        $display("mismatch: expected status %0d hop %h port %0d ttl %0d cost %0d len %0d",
                                 want.status, want.hop, want.port, want.ttl, want.cost, want.plen);
                        $display("          actual   status %0d hop %h port %0d ttl %0d cost %0d len %0d",
                                 got.status, got.hop, got.port, got.ttl, got.cost, got.plen);
                    end
                end
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 19);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int full_seen;
        full_seen = 0;

        // Directed rows. Literal answers are given where they are obvious: an empty
        // table, expiry, forwards that no route matches, and the status of adds and deletes.
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b0, '0, '0, '0, '0, '0, 32'h0102_0304, 8'd128),
                1'b1, '{lrt_pkg::ST_NOROUTE, 32'h0, 2'd0, 8'd127, 8'd0, 6'd0});
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF, 8'd0),
                1'b1, '{lrt_pkg::ST_EXPIRED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        add_row(make_req(lrt_pkg::OP_DELETE, 1'b0, '0, '0, '0, '0, '0, '0, '0),
                1'b1, '{lrt_pkg::ST_NOTFOUND, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        // Connected route given with host bits and a gateway, both of which it drops.
        add_row(make_req(lrt_pkg::OP_ADD, 1'b1, 32'hC0A8_01FF, 32'hFFFF_FF00, 32'hDEAD_BEEF,
                         2'd1, 8'd10, '0, '0),
                1'b1, '{lrt_pkg::ST_ADDED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        // Default route with the largest port and cost.
        add_row(make_req(lrt_pkg::OP_ADD, 1'b0, 32'h0, 32'h0, 32'h0A00_0001, 2'd3, 8'd255,
                         '0, '0),
                1'b1, '{lrt_pkg::ST_ADDED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        // Static route whose network has bits outside its mask.
        add_row(make_req(lrt_pkg::OP_ADD, 1'b0, 32'h0A00_00FF, 32'hFF00_0000, 32'h0B00_0001,
                         2'd0, 8'd1, '0, '0),
                1'b1, '{lrt_pkg::ST_ADDED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        // Host route with every address bit set.
        add_row(make_req(lrt_pkg::OP_ADD, 1'b0, '1, '1, '1, 2'd2, 8'd0, '0, '0),
                1'b1, '{lrt_pkg::ST_ADDED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b0, '0, '0, '0, '0, '0, 32'hC0A8_0155, 8'd255),
                1'b0, '0);
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b0, '0, '0, '0, '0, '0, 32'h0A00_0005, 8'd1),
                1'b0, '0);
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF, 8'd8),
                1'b0, '0);
        // Same /24 again as a static route: the earlier connected one must win the tie.
        add_row(make_req(lrt_pkg::OP_ADD, 1'b0, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0102_0304,
                         2'd2, 8'd7, '0, '0),
                1'b1, '{lrt_pkg::ST_ADDED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b0, '0, '0, '0, '0, '0, 32'hC0A8_0101, 8'd64),
                1'b0, '0);
        // Delete must compare with the stored, masked network.
        add_row(make_req(lrt_pkg::OP_DELETE, 1'b0, 32'hC0A8_01FF, 32'hFFFF_FF00, '0, '0, '0,
                         '0, '0),
                1'b1, '{lrt_pkg::ST_NOTFOUND, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        add_row(make_req(lrt_pkg::OP_DELETE, 1'b0, 32'hC0A8_0100, 32'hFFFF_FF00, '0, '0, '0,
                         '0, '0),
                1'b1, '{lrt_pkg::ST_DELETED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b0, '0, '0, '0, '0, '0, 32'hC0A8_0101, 8'd64),
                1'b0, '0);
        // The ignored op code, with every other field at its top value.
        add_row(make_req(OP_UNUSED, 1'b1, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0);
        add_row(make_req(lrt_pkg::OP_DELETE, 1'b0, 32'h0, 32'h0, '0, '0, '0, '0, '0),
                1'b1, '{lrt_pkg::ST_DELETED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b0, '0, '0, '0, '0, '0, 32'h1234_5678, 8'd2),
                1'b1, '{lrt_pkg::ST_NOROUTE, 32'h0, 2'd0, 8'd1, 8'd0, 6'd0});
        // The route with host bits cannot match even its own network address.
        add_row(make_req(lrt_pkg::OP_FORWARD, 1'b0, '0, '0, '0, '0, '0, 32'h0A00_00FF, 8'd3),
                1'b1, '{lrt_pkg::ST_NOROUTE, 32'h0, 2'd0, 8'd2, 8'd0, 6'd0});
        add_row(make_req(lrt_pkg::OP_DELETE, 1'b0, 32'h0A00_00FF, 32'hFF00_0000, '0, '0, '0,
                         '0, '0),
                1'b1, '{lrt_pkg::ST_DELETED, 32'h0, 2'd0, 8'd0, 8'd0, 6'd0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[k])
            send_route_op(stim_table[k].req, stim_table[k].has_literal, stim_table[k].literal);
        wait_results_drained();

        // Small table with idling on both sides.
        run_mix(700, 12);

        // Back-to-back traffic with neither side of the bus inserting idle cycles.
        steady = 1'b1;
        run_mix(300, 6);
        steady = 1'b0;
        wait_results_drained();

        // Fill the table until adds bounce off the full table for a while.
        while (full_seen < 12)
        begin
            send_route_op(rand_route_op(80, 0), 1'b0, '0);
            if (shadow_count == TBL_DEPTH)
                full_seen++;
        end

        // Empty it again, mostly through deletes of existing routes.
        while (shadow_count > 4)
            send_route_op(rand_route_op(0, 85), 1'b0, '0);

        run_mix(600, 24);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
